// ----- rtl/core/tdp_pkg.sv -----
// Shared command and status types for the trial-division prime test core.
package tdp_pkg;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture candidate, set divisor to two
    logic div_start;   // clear remainder, reload dividend shifter
    logic div_step;    // one restoring-division bit
    logic advance;     // next divisor and its square
    logic verdict_en;  // write the verdict register
    logic verdict_val; // value for the verdict register
  } tdp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic trivial;     // negative, zero or one
    logic sq_gt_n;     // divisor squared exceeds candidate
    logic div_last;    // final bit of the division
    logic rem_zero;    // remainder is zero
  } tdp_sts_t;

endpackage

// ----- rtl/core/tdp_datapath.sv -----
// Datapath: candidate, divisor, running square and a bit-serial remainder unit.
module tdp_datapath import tdp_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [VALUE_WIDTH-1:0] candidate_i,
  input  tdp_cmd_t               cmd_i,
  output tdp_sts_t               sts_o,
  output logic                   is_prime_o
);

  localparam int unsigned W    = VALUE_WIDTH;
  localparam int unsigned CntW = $clog2(W);

  logic [W-1:0]    n_q, n_d;
  logic [W-1:0]    d_q, d_d;
  logic [W:0]      sq_q, sq_d;
  logic [W-1:0]    rem_q, rem_d;
  logic [W-1:0]    sh_q, sh_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            prime_q, prime_d;

  logic [W:0]   trial;
  logic [W-1:0] diff;
  logic         geq;

  // trial is below twice the divisor, so the low bits of the difference suffice
  assign trial = {rem_q, sh_q[W-1]};
  assign diff  = trial[W-1:0] - d_q;
  assign geq   = trial >= {1'b0, d_q};

  always_comb begin
    n_d     = n_q;
    d_d     = d_q;
    sq_d    = sq_q;
    rem_d   = rem_q;
    sh_d    = sh_q;
    cnt_d   = cnt_q;
    prime_d = prime_q;
    if (cmd_i.load) begin
      n_d  = candidate_i;
      d_d  = W'(2);
      sq_d = (W + 1)'(4);
    end
    if (cmd_i.div_start) begin
      rem_d = '0;
      sh_d  = n_q;
      cnt_d = CntW'(W - 1);
    end
    if (cmd_i.div_step) begin
      rem_d = geq ? diff : trial[W-1:0];
      sh_d  = {sh_q[W-2:0], 1'b0};
      cnt_d = cnt_q - CntW'(1);
    end
    if (cmd_i.advance) begin
      // (d+1)^2 = d^2 + 2d + 1
      d_d  = d_q + W'(1);
      sq_d = sq_q + {d_q, 1'b1};
    end
    if (cmd_i.verdict_en) begin
      prime_d = cmd_i.verdict_val;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    d_q   <= d_d;
    sq_q  <= sq_d;
    rem_q <= rem_d;
    sh_q  <= sh_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      prime_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      prime_q <= prime_d;
    end
  end

  assign sts_o.trivial  = n_q[W-1] | (n_q[W-1:1] == '0);
  assign sts_o.sq_gt_n  = sq_q > {1'b0, n_q};
  assign sts_o.div_last = cnt_q == '0;
  assign sts_o.rem_zero = rem_q == '0;
  assign is_prime_o     = prime_q;

endmodule

// ----- rtl/core/tdp_controller.sv -----
// Controller: sequences the divisor loop and the bit-serial remainder.
module tdp_controller import tdp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  tdp_sts_t sts_i,
  output tdp_cmd_t cmd_o,
  output logic     busy_o,
  output logic     done_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StCheck = 3'd1;
  localparam logic [2:0] StDiv   = 3'd2;
  localparam logic [2:0] StTest  = 3'd3;
  localparam logic [2:0] StDone  = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = StCheck;
        end
      end
      StCheck: begin
        if (sts_i.trivial) begin
          cmd_o.verdict_en  = 1'b1;
          cmd_o.verdict_val = 1'b0;
          state_d           = StDone;
        end else if (sts_i.sq_gt_n) begin
          cmd_o.verdict_en  = 1'b1;
          cmd_o.verdict_val = 1'b1;
          state_d           = StDone;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = StDiv;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = StTest;
        end
      end
      StTest: begin
        if (sts_i.rem_zero) begin
          cmd_o.verdict_en  = 1'b1;
          cmd_o.verdict_val = 1'b0;
          state_d           = StDone;
        end else begin
          cmd_o.advance = 1'b1;
          state_d       = StCheck;
        end
      end
      StDone: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = state_q != StIdle;
  assign done_o = state_q == StDone;

endmodule

// ----- rtl/core/trial_division_prime_test_core.sv -----
// Top level of the trial-division prime test core.
//
// Pulse start_i while busy_o is low to transfer one candidate; the value is
// read as a VALUE_WIDTH-bit two's complement number. In the cycle after the
// last step of the search, done_o is high for a single cycle with the
// verdict on is_prime_o; the receiver cannot stall, so sample it then. Negative
// values, zero and one are not prime. Otherwise divisors 2, 3, 4, ... are tried
// while divisor squared does not exceed the candidate, the square being kept
// as a running sum so no multiplier is needed. Each divisor passes through a
// compare state, the one-bit-per-cycle restoring remainder unit and a test
// state; a divisor that divides ends the search in the test state. At 32 bits
// a large prime needs about 46340 divisors. busy_o stays high from the
// transfer until the cycle after done_o.
module trial_division_prime_test_core import tdp_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [VALUE_WIDTH-1:0] candidate_i,
  output logic                   busy_o,
  output logic                   done_o,
  output logic                   is_prime_o
);

  // Command and status between the sequencer and the arithmetic.
  tdp_cmd_t cmd;
  tdp_sts_t sts;

  // Sequence: check bound, divide bit by bit, test remainder, advance divisor.
  tdp_controller u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy_o),
    .done_o (done_o)
  );

  // Hold candidate, divisor, square and remainder; drive the verdict register.
  tdp_datapath #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .candidate_i(candidate_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .is_prime_o (is_prime_o)
  );

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the trial-division prime test core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAND_W = 32;
  // Generous ceiling: the largest positive candidate alone runs the full divisor
  // search, and the rest of the run is far shorter.
  localparam longint unsigned RUN_LIMIT_NS = 64'd200_000_000;

  typedef struct {
    logic [CAND_W-1:0] value;
    bit                steady;   // no random gap before this transfer
  } trial_t;

  typedef struct {
    logic [CAND_W-1:0] value;
    bit                verdict;
  } verdict_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start_i;
  logic [CAND_W-1:0] candidate_i;
  logic              busy_o;
  logic              done_o;
  logic              is_prime_o;

  trial_t   trials_pending[$];
  verdict_t verdicts_due[$];

  bit taken;        // set by the monitor when the driven candidate was transferred
  int n_queued;
  int n_taken;
  int n_verdicts;
  int n_primes;
  int n_negative;
  int n_errors;

  trial_division_prime_test_core #(
    .VALUE_WIDTH(CAND_W)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .candidate_i(candidate_i),
    .busy_o     (busy_o),
    .done_o     (done_o),
    .is_prime_o (is_prime_o)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Trial division on the candidate read as a signed value: anything negative,
  // zero or one is not prime, otherwise test divisors while d*d <= n. The bound
  // is written as d <= n / d so that it cannot wrap near the top of the range.
  function automatic bit prime_verdict(logic [CAND_W-1:0] n);
    logic [CAND_W-1:0] d;
    if (n[CAND_W-1]) return 1'b0;
    if (n <= 1) return 1'b0;
    for (d = 2; d <= n / d; d++) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Driver: change inputs on the falling edge. Hold start high until the
  // transfer is seen, then pick the next candidate or drop start for a gap.
  always @(negedge clk_i) begin
    logic   next_start;
    trial_t nxt;
    if (rst_ni && !(start_i && !taken)) begin
      taken = 1'b0;
      next_start = 1'b0;
      if (trials_pending.size() > 0) begin
        nxt = trials_pending[0];
        if (nxt.steady || $urandom_range(0, 99) >= 19) begin
          next_start = 1'b1;
          void'(trials_pending.pop_front());
          candidate_i <= nxt.value;
        end
      end
      // Scramble the candidate bus while no transfer is offered.
      if (!next_start) candidate_i <= CAND_W'($urandom);
      start_i <= next_start;
    end
  end

  // Monitor: sample on the rising edge. Retire the oldest verdict on done_o,
  // then log a new expectation for any candidate transferred at this edge.
  always @(posedge clk_i) begin
    verdict_t due;
    if (rst_ni) begin
      if (done_o === 1'b1) begin
        n_verdicts++;
        if (verdicts_due.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("result strobe with no candidate outstanding");
        end else begin
          due = verdicts_due.pop_front();
          if (is_prime_o !== due.verdict) begin
            n_errors++;
            if (n_errors <= 10)
              $display("verdict mismatch: candidate %0d expected %0b got %0b",
                       $signed(due.value), due.verdict, is_prime_o);
          end
        end
      end
      if (start_i === 1'b1 && busy_o === 1'b0) begin
        due.value   = candidate_i;
        due.verdict = prime_verdict(candidate_i);
        verdicts_due.push_back(due);
        if (due.verdict) n_primes++;
        if (candidate_i[CAND_W-1]) n_negative++;
        n_taken++;
        taken = 1'b1;
      end
    end
  end

  // Hard stop in case the core hangs.
  initial begin
    #(RUN_LIMIT_NS);
    $display("timeout: %0d of %0d candidates transferred, %0d verdicts outstanding",
             n_taken, n_queued, verdicts_due.size());
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [CAND_W-1:0] directed[$];
    logic [CAND_W-1:0] v;
    int unsigned       pick;
    int unsigned       p;
    int unsigned       f;

    rst_ni      = 1'b0;
    start_i     = 1'b0;
    candidate_i = '0;

    // Directed set: trivial values, small primes and squares where the divisor
    // loop ends exactly on d*d == n, the sign extremes, and the largest positive
    // value (a prime, so the full search runs right up to the square bound).
    directed = '{
      32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd25, 32'd49, 32'd121,
      32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0001,
      32'd65521, 32'd65537, 32'd1000003, 32'd46340 * 32'd46340,
      32'h7FFF_FFFE, 32'h7FFF_FFFD, 32'h5555_5555, 32'h2AAA_AAAA,
      32'h7FFF_FFFF
    };
    foreach (directed[i]) begin
      trials_pending.push_back('{value: directed[i], steady: 1'b0});
      n_queued++;
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Pause the sender until every directed verdict has come back.
    while (!(n_taken == n_queued && verdicts_due.size() == 0)) @(posedge clk_i);
    repeat (3) @(posedge clk_i);

    // Random mix: mostly small values, products of two nearby small factors,
    // full-width values with a small factor, and negatives. Large primes are
    // kept out since each one runs the whole divisor search.
    for (int i = 0; i < 80; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        v = CAND_W'($urandom_range(0, 4095));
      end else if (pick < 38) begin
        v = CAND_W'($urandom_range(4096, 32'h000F_FFFF));
      end else if (pick < 58) begin
        p = $urandom_range(2, 255);
        v = CAND_W'(p * $urandom_range(p, p + 12));
      end else if (pick < 78) begin
        f = $urandom_range(2, 7);
        v = CAND_W'(f * $urandom_range(1, 32'h7FFF_FFFF / f));
      end else begin
        v = {1'b1, 31'($urandom)};
      end
      // A stretch in the middle goes back to back with no gaps.
      trials_pending.push_back('{value: v, steady: (i >= 30 && i < 60)});
      n_queued++;
    end

    while (!(n_taken == n_queued && verdicts_due.size() == 0)) @(posedge clk_i);
    repeat (5) @(posedge clk_i);

    $display("%0d candidates transferred, %0d verdicts checked", n_taken, n_verdicts);
    $display("%0d expected prime, %0d negative, %0d errors", n_primes, n_negative, n_errors);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
